// ===== rtl/scno_pkg.sv =====
// Shared types, constants and table functions for the scan corridor
// nearest-obstacle block. No dependencies.
package scno_pkg;

  localparam int SINE_ENTRIES = 1024;
  localparam int IDX_W        = $clog2(SINE_ENTRIES + 1);
  localparam int FRAC_W       = 14;
  localparam int PROD_W       = FRAC_W + IDX_W;
  localparam int MAG_W        = 15;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [15:0] PHASE_HALF     = 16'h8000;
  localparam logic [15:0] PHASE_QUARTER  = 16'h4000;
  localparam logic [15:0] HALF_WIDTH_RST = 16'd500;
  localparam logic [15:0] ANGLE_STEP_RST = 16'd182;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  typedef enum logic {
    REG_HALF_WIDTH = 1'b0,
    REG_ANGLE_STEP = 1'b1
  } reg_sel_t;

  typedef logic [IDX_W-1:0] tab_addr_t;
  typedef logic [MAG_W-1:0] sin_tab_t [0:SINE_ENTRIES];

  typedef struct packed {
    logic [15:0] range_mm;
    logic        scan_end;
    tab_addr_t   sin_addr;
    tab_addr_t   cos_addr;
    logic        fwd_pos;   // cosine quadrant is non-negative
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Quarter-wave entry k: Q30 Taylor series up to the 13th power, scaled to unsigned 0.15
  function automatic logic [MAG_W-1:0] sin_entry(int unsigned k);
    logic [63:0] th;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    th   = (64'(k) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
    term = th;
    sum  = th;
    term = (((term * th) >> 30) * th) >> 30;
    term = term / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = (((term * th) >> 30) * th) >> 30;
    term = term / 64'd20;
    sum  = sum + term;
    term = (((term * th) >> 30) * th) >> 30;
    term = term / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = (((term * th) >> 30) * th) >> 30;
    term = term / 64'd72;
    sum  = sum + term;
    term = (((term * th) >> 30) * th) >> 30;
    term = term / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = (((term * th) >> 30) * th) >> 30;
    term = term / 64'd156;
    sum  = sum + term;
    v = (sum * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return MAG_W'(v);
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    for (int unsigned k = 0; k <= SINE_ENTRIES; k++) begin
      t[k] = sin_entry(k);
    end
    return t;
  endfunction

  // Table address of |sin(ph)|; odd quadrants read the table mirrored
  function automatic tab_addr_t tab_addr(logic [15:0] ph);
    logic [PROD_W-1:0] prod;
    tab_addr_t         idx;
    prod = PROD_W'(ph[FRAC_W-1:0]) * PROD_W'(SINE_ENTRIES);
    idx  = IDX_W'(prod >> FRAC_W);
    if (ph[14]) begin
      return IDX_W'(SINE_ENTRIES) - idx;
    end
    return idx;
  endfunction

endpackage

// ===== rtl/scan_corridor_nearest_obstacle.sv =====
// Corridor nearest-obstacle finder over lidar range words.
// Throughput: one word per cycle, set by the ROM, multiply and compare stages
// behind a 4-word queue, except while a scan-end word waits on a full result
// register that the output stalls.
// Reset: half width 500, angle step 182, phase at half turn, minimum 65535,
// found clear, queue empty. No clearing pass.
module scan_corridor_nearest_obstacle (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_range_mm,
  input  logic        in_scan_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_nearest_forward_mm,
  output logic        out_obstacle_found,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scno_pkg::*;

  logic [15:0] half_width_r;
  logic [15:0] angle_step_r;
  reg_sel_t    reg_sel;
  logic        cfg_wr;
  logic        push;
  logic        pop;
  logic        tail_busy;
  q_item_t     push_item;
  q_item_t     head;
  q_status_t   q_st;

  assign pready  = 1'b1;
  assign reg_sel = reg_sel_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign in_stall = q_st.full;

  always_comb begin
    case (reg_sel)
      REG_HALF_WIDTH: prdata = {16'd0, half_width_r};
      REG_ANGLE_STEP: prdata = {16'd0, angle_step_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_WIDTH_RST;
      angle_step_r <= ANGLE_STEP_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_HALF_WIDTH: half_width_r <= pwdata[15:0];
        REG_ANGLE_STEP: angle_step_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  scno_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_range_mm (in_range_mm),
    .in_scan_end (in_scan_end),
    .angle_step  (angle_step_r),
    .q_st        (q_st),
    .push        (push),
    .push_item   (push_item)
  );

  scno_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_st      (q_st)
  );

  scno_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head                   (head),
    .q_st                   (q_st),
    .half_width_mm          (half_width_r),
    .pop                    (pop),
    .tail_busy              (tail_busy),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_nearest_forward_mm (out_nearest_forward_mm),
    .out_obstacle_found     (out_obstacle_found)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    q_st.full |-> !q_st.empty)
    else $error("queue flags full and empty together");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(tail_busy))
    else $error("result raised without a word in the last stage");

  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !tail_busy) |=> !out_valid)
    else $error("result word delivered twice");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_st.full && !pop) |=> !$past(push))
    else $error("word pushed into a full queue");

endmodule

// ===== rtl/scno_front.sv =====
// Front end: accepts sample words, steps the bearing phase and works out
// the table addresses. Depends on scno_pkg.
module scno_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [15:0]         in_range_mm,
  input  logic                in_scan_end,
  input  logic [15:0]         angle_step,
  input  scno_pkg::q_status_t q_st,
  output logic                push,
  output scno_pkg::q_item_t   push_item
);
  import scno_pkg::*;

  logic [15:0] phase_acc_r;
  logic [15:0] phase_acc_nxt;
  logic [15:0] cos_phase;

  assign push      = in_valid && !q_st.full;
  assign cos_phase = phase_acc_r + PHASE_QUARTER;

  always_comb begin
    push_item.range_mm = in_range_mm;
    push_item.scan_end = in_scan_end;
    push_item.sin_addr = tab_addr(phase_acc_r);
    push_item.cos_addr = tab_addr(cos_phase);
    push_item.fwd_pos  = !cos_phase[15];
  end

  always_comb begin
    phase_acc_nxt = phase_acc_r;
    if (push) begin
      phase_acc_nxt = in_scan_end ? PHASE_HALF : phase_acc_r + angle_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= PHASE_HALF;
    end else begin
      phase_acc_r <= phase_acc_nxt;
    end
  end

endmodule

// ===== rtl/scno_queue.sv =====
// Short word queue between front and back end.
// Depends on scno_pkg.
module scno_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  scno_pkg::q_item_t   push_item,
  input  logic                pop,
  output scno_pkg::q_item_t   head,
  output scno_pkg::q_status_t q_st
);
  import scno_pkg::*;

  q_item_t           mem_r [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign head     = mem_r[rd_ptr_r];
  assign q_st.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_st.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/scno_back.sv =====
// Back end: sine ROM read, projection multiplies, corridor test and
// running minimum, result register. Depends on scno_pkg.
module scno_back (
  input  logic                clk,
  input  logic                rst_n,
  input  scno_pkg::q_item_t   head,
  input  scno_pkg::q_status_t q_st,
  input  logic [15:0]         half_width_mm,
  output logic                pop,
  output logic                tail_busy,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_nearest_forward_mm,
  output logic                out_obstacle_found
);
  import scno_pkg::*;

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  logic             en;
  // stage A: table read
  logic             va_r;
  logic [15:0]      range_a_r;
  logic             last_a_r;
  logic             pos_a_r;
  logic [MAG_W-1:0] smag_r;
  logic [MAG_W-1:0] cmag_r;
  // stage B: projections
  logic             vb_r;
  logic             last_b_r;
  logic             pos_b_r;
  logic [15:0]      lat_b_r;
  logic [15:0]      fwd_b_r;
  logic [30:0]      lat_prod;
  logic [30:0]      fwd_prod;
  // scan state
  logic [15:0]      min_r;
  logic             seen_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [15:0]      out_fwd_r;
  logic             out_found_r;
  logic             take;
  logic             hit;
  logic [15:0]      min_cur;
  logic             seen_cur;

  // only a scan-end word waiting on a full result register holds the pipe
  assign en        = !(vb_r && last_b_r && out_valid_r && out_stall);
  assign pop       = en && !q_st.empty;
  assign take      = vb_r && en;
  assign tail_busy = vb_r;

  assign lat_prod = 31'(range_a_r) * 31'(smag_r) + 31'd16384;
  assign fwd_prod = 31'(range_a_r) * 31'(cmag_r) + 31'd16384;

  always_comb begin
    hit      = pos_b_r && (lat_b_r < half_width_mm) && (fwd_b_r != 16'd0);
    min_cur  = (hit && (fwd_b_r < min_r)) ? fwd_b_r : min_r;
    seen_cur = seen_r || hit;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (take && last_b_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      min_r       <= 16'hFFFF;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (en) begin
        va_r <= !q_st.empty;
        vb_r <= va_r;
      end
      if (take) begin
        if (last_b_r) begin
          min_r  <= 16'hFFFF;
          seen_r <= 1'b0;
        end else begin
          min_r  <= min_cur;
          seen_r <= seen_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      range_a_r <= head.range_mm;
      last_a_r  <= head.scan_end;
      pos_a_r   <= head.fwd_pos;
      smag_r    <= SIN_TAB[head.sin_addr];
      cmag_r    <= SIN_TAB[head.cos_addr];
      last_b_r  <= last_a_r;
      pos_b_r   <= pos_a_r;
      lat_b_r   <= lat_prod[30:15];
      fwd_b_r   <= fwd_prod[30:15];
    end
    if (take && last_b_r) begin
      out_fwd_r   <= min_cur;
      out_found_r <= seen_cur;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_nearest_forward_mm = out_fwd_r;
  assign out_obstacle_found     = out_found_r;

endmodule
